// File: rtl/rst_pkg.sv
`default_nettype none
package rst_pkg;
  localparam int NumGroupsDef = 16;
  localparam int ListDepthDef = 256;
  localparam int EntryW = 78;

  typedef enum logic [1:0] {
    CmdUpdate = 2'd0,
    CmdRemove = 2'd1,
    CmdRead   = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StDone    = 3'd0,
    StIgnored = 3'd1,
    StMissing = 3'd2,
    StDropped = 3'd3,
    StEmpty   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SFind, SFindW, SDel, SDelW, SSrch, SSrchW, SShift, SShiftW,
    SWrite, SRead, SReadW, SOut
  } back_st_e;

  typedef struct packed {
    logic        valid_grp;
    cmd_e        cmd;
    logic [3:0]  grp;
    logic [31:0] id;
    logic [5:0]  tier;
    logic [39:0] score;
    logic        excluded;
    logic        keep;
    logic [7:0]  rank;
  } job_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  rank;
    logic [31:0] id;
    logic [5:0]  tier;
    logic [39:0] score;
    logic [8:0]  count;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/rst_ram.sv
`default_nettype none
module rst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/rst_front.sv
`default_nettype none
module rst_front #(
  parameter int NumGroups = rst_pkg::NumGroupsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic [1:0]           command_i,
  input  wire logic [3:0]           group_id_i,
  input  wire logic [31:0]          player_id_i,
  input  wire logic [5:0]           tier_i,
  input  wire logic [39:0]          score_i,
  input  wire logic                 excluded_i,
  input  wire logic                 keep_existing_i,
  input  wire logic [7:0]           rank_index_i,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i,
  output rst_pkg::job_t             job_o
);
  // two-entry queue
  rst_pkg::job_t q_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  rst_pkg::job_t in_job;
  logic push, pop;

  always_comb begin
    in_job.valid_grp = ({28'd0, group_id_i} < 32'(NumGroups));
    in_job.cmd       = rst_pkg::cmd_e'(command_i);
    in_job.grp       = group_id_i;
    in_job.id        = player_id_i;
    in_job.tier      = tier_i;
    in_job.score     = score_i;
    in_job.excluded  = excluded_i;
    in_job.keep      = keep_existing_i;
    in_job.rank      = rank_index_i;
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wr_q] <= in_job;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> rd_q == wr_q) else $error("queue pointers");
`endif
endmodule
`default_nettype wire

// File: rtl/rst_back.sv
`default_nettype none
module rst_back #(
  parameter int NumGroups = rst_pkg::NumGroupsDef,
  parameter int ListDepth = rst_pkg::ListDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  output logic               job_ready_o,
  input  wire rst_pkg::job_t job_i,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output rst_pkg::res_t      res_o
);
  localparam int GW = (NumGroups > 1) ? $clog2(NumGroups) : 1;
  localparam int PW = $clog2(ListDepth);
  localparam int CW = PW + 1;
  localparam int AW = GW + PW;
  localparam int EW = rst_pkg::EntryW;

  rst_pkg::back_st_e st_q, st_d;
  rst_pkg::job_t job_q;
  logic [CW-1:0] cnt_q [NumGroups];
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          drop_q, drop_d;
  rst_pkg::res_t res_q, res_d;
  logic          rv_q, rv_d;
  logic          cnt_we;
  logic [CW-1:0] cnt_wv;
  logic          take;

  logic          we;
  logic [PW-1:0] waddr_p, raddr_p;
  logic [EW-1:0] wdata, rdata;
  logic [GW-1:0] g, g_in;

  assign g    = GW'(job_q.grp);
  assign g_in = GW'(job_i.grp);

  rst_ram #(.Width(EW), .Depth(1 << AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i ({g, waddr_p}),
    .wdata_i (wdata),
    .raddr_i ({g, raddr_p}),
    .rdata_o (rdata)
  );

  logic [31:0] r_id;
  logic [5:0]  r_tier;
  logic [39:0] r_score;
  assign {r_id, r_tier, r_score} = rdata;

  // hold new jobs while a result waits
  assign job_ready_o = (st_q == rst_pkg::SIdle) && !rv_q;
  assign take        = job_valid_i && job_ready_o;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_comb begin
    st_d = st_q; n_d = n_q; i_d = i_q; pos_d = pos_q; drop_d = drop_q;
    res_d = res_q; rv_d = rv_q; we = 1'b0;
    waddr_p = i_q[PW-1:0]; raddr_p = i_q[PW-1:0]; wdata = rdata;
    cnt_we = 1'b0; cnt_wv = n_q;
    if (rv_q && res_ready_i) rv_d = 1'b0;
    case (st_q)
      rst_pkg::SIdle: begin
        i_d = '0; drop_d = 1'b0;
        if (take) begin
          n_d = job_i.valid_grp ? cnt_q[g_in] : '0;
          res_d = '0;
          res_d.status = rst_pkg::StIgnored;
          if (!job_i.valid_grp) begin
            st_d = rst_pkg::SOut;
          end else begin
            case (job_i.cmd)
              rst_pkg::CmdUpdate: begin
                if (job_i.excluded) st_d = rst_pkg::SOut;
                else if (job_i.keep) st_d = rst_pkg::SSrch;
                else st_d = rst_pkg::SFind;
              end
              rst_pkg::CmdRemove: st_d = rst_pkg::SFind;
              rst_pkg::CmdRead: begin
                if ({24'd0, job_i.rank} < 32'(cnt_q[g_in])) begin
                  st_d = rst_pkg::SRead;
                end else begin
                  res_d.status = rst_pkg::StEmpty;
                  st_d = rst_pkg::SOut;
                end
              end
              default: st_d = rst_pkg::SOut;
            endcase
          end
        end
      end
      rst_pkg::SFind: begin
        if (i_q >= n_q) begin
          pos_d = n_q;
          st_d = (job_q.cmd == rst_pkg::CmdRemove) ? rst_pkg::SOut : rst_pkg::SSrch;
          if (job_q.cmd == rst_pkg::CmdRemove) res_d.status = rst_pkg::StMissing;
          i_d = '0;
        end else begin
          st_d = rst_pkg::SFindW;
        end
      end
      rst_pkg::SFindW: begin
        if (r_id == job_q.id) begin
          pos_d = i_q;
          i_d = i_q;
          st_d = rst_pkg::SDel;
        end else begin
          i_d = i_q + 1'b1;
          st_d = rst_pkg::SFind;
        end
      end
      rst_pkg::SDel: begin
        // compact: move entry i+1 down to i
        if (i_q + 1'b1 >= n_q) begin
          n_d = n_q - 1'b1;
          i_d = '0;
          if (job_q.cmd == rst_pkg::CmdRemove) begin
            res_d.status = rst_pkg::StDone;
            res_d.rank = 8'(pos_q);
            cnt_we = 1'b1; cnt_wv = n_q - 1'b1;
            res_d.count = 9'(n_q - 1'b1);
            rv_d = 1'b1;
            st_d = rst_pkg::SIdle;
          end else begin
            st_d = rst_pkg::SSrch;
          end
        end else begin
          raddr_p = PW'(i_q + 1'b1);
          st_d = rst_pkg::SDelW;
        end
      end
      rst_pkg::SDelW: begin
        we = 1'b1; waddr_p = i_q[PW-1:0];
        i_d = i_q + 1'b1;
        st_d = rst_pkg::SDel;
      end
      rst_pkg::SSrch: begin
        if (i_q == '0 && n_q >= CW'(ListDepth)) begin
          n_d = CW'(ListDepth - 1);
          drop_d = 1'b1;
        end else if (i_q >= n_q) begin
          pos_d = n_q; i_d = n_q; st_d = rst_pkg::SShift;
        end else begin
          st_d = rst_pkg::SSrchW;
        end
      end
      rst_pkg::SSrchW: begin
        if (r_tier < job_q.tier || (r_tier == job_q.tier && r_score < job_q.score)) begin
          pos_d = i_q; i_d = n_q; st_d = rst_pkg::SShift;
        end else begin
          i_d = i_q + 1'b1; st_d = rst_pkg::SSrch;
        end
      end
      rst_pkg::SShift: begin
        // move entry i-1 up to i, from the tail down
        if (i_q <= pos_q) begin
          st_d = rst_pkg::SWrite;
        end else begin
          raddr_p = PW'(i_q - 1'b1);
          st_d = rst_pkg::SShiftW;
        end
      end
      rst_pkg::SShiftW: begin
        we = 1'b1; waddr_p = i_q[PW-1:0];
        i_d = i_q - 1'b1;
        st_d = rst_pkg::SShift;
      end
      rst_pkg::SWrite: begin
        we = 1'b1; waddr_p = pos_q[PW-1:0];
        wdata = {job_q.id, job_q.tier, job_q.score};
        cnt_we = 1'b1; cnt_wv = n_q + 1'b1;
        res_d.status = drop_q ? rst_pkg::StDropped : rst_pkg::StDone;
        res_d.rank = 8'(pos_q);
        res_d.count = 9'(n_q + 1'b1);
        rv_d = 1'b1;
        st_d = rst_pkg::SIdle;
      end
      rst_pkg::SRead: begin
        raddr_p = PW'(job_q.rank);
        st_d = rst_pkg::SReadW;
      end
      rst_pkg::SReadW: begin
        res_d.status = rst_pkg::StDone;
        res_d.rank = job_q.rank;
        res_d.id = r_id; res_d.tier = r_tier; res_d.score = r_score;
        res_d.count = 9'(n_q);
        rv_d = 1'b1;
        st_d = rst_pkg::SIdle;
      end
      rst_pkg::SOut: begin
        res_d.count = job_q.valid_grp ? 9'(n_q) : 9'd0;
        rv_d = 1'b1;
        st_d = rst_pkg::SIdle;
      end
      default: st_d = rst_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= rst_pkg::SIdle;
      rv_q <= 1'b0;
      for (int k = 0; k < NumGroups; k++) cnt_q[k] <= '0;
    end else begin
      st_q <= st_d;
      rv_q <= rv_d;
      if (cnt_we) cnt_q[g] <= cnt_wv;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; pos_q <= pos_d; drop_q <= drop_d;
    res_q <= res_d;
    n_q <= n_d;
    if (take) job_q <= job_i;
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != rst_pkg::SIdle |-> !job_ready_o) else $error("ready while busy");
  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> !job_ready_o) else $error("ready while result waits");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q && !res_ready_i |=> rv_q && $stable(res_q)) else $error("result dropped");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != rst_pkg::SIdle |-> n_q <= CW'(ListDepth)) else $error("count overflow");
`endif
endmodule
`default_nettype wire

// File: rtl/ranked_sorted_table.sv
`default_nettype none
// Ranked sorted table: one descending list per group, keyed by tier then
// score. The front accepts items into a two-entry queue; the back walks the
// list one entry at a time through the RAM read port, in an address state
// and then a data state. An update first finds the id and compacts the list
// to remove it, then searches for the insertion point and shifts the tail
// up; keep_existing skips the find. A remove does only the find and the
// compaction, a read fetches one entry and an ignored item goes straight to
// the result. Each item gives exactly one result, held in an output
// register until transferred; the back takes no new item while a result
// waits, so the input stalls once the queue holds two items.
module ranked_sorted_table #(
  parameter int NumGroups = rst_pkg::NumGroupsDef,
  parameter int ListDepth = rst_pkg::ListDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  group_id_i,
  input  wire logic [31:0] player_id_i,
  input  wire logic [5:0]  tier_i,
  input  wire logic [39:0] score_i,
  input  wire logic        excluded_i,
  input  wire logic        keep_existing_i,
  input  wire logic [7:0]  rank_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       rank_out_o,
  output logic [31:0]      id_out_o,
  output logic [5:0]       tier_out_o,
  output logic [39:0]      score_out_o,
  output logic [8:0]       list_count_o
);
  logic          jv, jr;
  rst_pkg::job_t job;
  rst_pkg::res_t res;

  rst_front #(.NumGroups(NumGroups)) u_front (
    .clk_i, .rst_ni, .valid_i(in_valid_i), .ready_o(in_ready_o),
    .command_i, .group_id_i, .player_id_i, .tier_i, .score_i,
    .excluded_i, .keep_existing_i, .rank_index_i,
    .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  rst_back #(.NumGroups(NumGroups), .ListDepth(ListDepth)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_ready_o(jr), .job_i(job),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign status_o     = res.status;
  assign rank_out_o   = res.rank;
  assign id_out_o     = res.id;
  assign tier_out_o   = res.tier;
  assign score_out_o  = res.score;
  assign list_count_o = res.count;
endmodule
`default_nettype wire
